>>> hdl/stag_pkg.sv
`default_nettype none

package stag_pkg;

   // walk geometry
   localparam int OUTER_BLOCK = 32;
   localparam int INNER_BLOCK = 4;
   localparam int MAX_DIM     = 4096;

   // field widths
   localparam int DIM_W     = 13;
   localparam int STRIDE_W  = 16;
   localparam int OFF_W     = 29;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // index widths derived from the geometry
   localparam int IDX_W  = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
   localparam int TILE_W = (INNER_BLOCK > 1) ? $clog2(INNER_BLOCK) : 1;
   localparam int CMP_W  = $clog2(MAX_DIM + OUTER_BLOCK + 1);
   localparam int PROD_W = IDX_W + STRIDE_W;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS           = 3'd0,
      CSR_COLS           = 3'd1,
      CSR_SRC_ROW_STRIDE = 3'd2,
      CSR_SRC_COL_STRIDE = 3'd3,
      CSR_DST_ROW_STRIDE = 3'd4,
      CSR_DST_COL_STRIDE = 3'd5,
      CSR_BLOCKED_ORDER  = 3'd6
   } csr_index_type;

endpackage

`default_nettype wire

>>> hdl/strided_transpose_address_generator_unit.sv
`default_nettype none

// channel   direction  handshake                 payload
// req_      in         req_valid / req_stall     req_restart
// rsp_      out        rsp_valid / rsp_stall     rsp_valid_res, rsp_src_offset,
//                                                rsp_dst_offset, rsp_last
// csr_      in         csr_valid / csr_ready     csr_index, csr_data
//
// one item per clock unless rsp_stall holds the pipeline; three registers per item
// (walk step, stride multipliers, offset adders): an accepted item loads the stage
// one register, then the stride products, then the result register, where it is taken
// the walk step is combinational, which sets the one-item rate
// reset clears the registers to their defaults and leaves no walk active
// a stalled result holds the pipeline; req_stall rises only when all stages are full

module strided_transpose_address_generator_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_restart,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_valid_res,
   output logic [stag_pkg::OFF_W-1:0]          rsp_src_offset,
   output logic [stag_pkg::OFF_W-1:0]          rsp_dst_offset,
   output logic                                rsp_last,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [stag_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [stag_pkg::CSR_DAT_W-1:0] csr_data
);
   import stag_pkg::*;

   // configuration registers
   logic [DIM_W-1:0]    rows_ff, cols_ff;
   logic [STRIDE_W-1:0] src_row_stride_ff, src_col_stride_ff;
   logic [STRIDE_W-1:0] dst_row_stride_ff, dst_col_stride_ff;
   logic                blocked_order_ff;

   // walk state
   logic [IDX_W-1:0]  outer_row_ff, outer_col_ff, inner_row_ff, inner_col_ff;
   logic [TILE_W-1:0] row_tile_ff, col_tile_ff;
   logic              walk_done_ff;
   logic [IDX_W-1:0]  outer_row_in, outer_col_in, inner_row_in, inner_col_in;
   logic [TILE_W-1:0] row_tile_in, col_tile_in;
   logic              walk_done_in;

   // pipeline stages
   logic              s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic              s1_vres_ff, s2_vres_ff, s3_vres_ff;
   logic              s1_last_ff, s2_last_ff, s3_last_ff;
   logic [IDX_W-1:0]  s1_row_ff, s1_col_ff;
   logic [PROD_W-1:0] p_src_row_ff, p_src_col_ff, p_dst_row_ff, p_dst_col_ff;
   logic [OFF_W-1:0]  s3_src_ff, s3_dst_ff;
   logic              s1_vres_in, s1_last_in;
   logic [IDX_W-1:0]  s1_row_in, s1_col_in;

   logic              accept, mv2, mv3, s1_free, s2_free;

   // working values of the walk step
   logic [CMP_W-1:0]  nr, nc;
   logic [IDX_W-1:0]  orow, ocol, irow, icol;
   logic [TILE_W-1:0] rtile, ctile;
   logic              done_cur, pos_ok, fin;
   logic [CMP_W-1:0]  orow_x, ocol_x, irow_x, icol_x, rtile_x, ctile_x;
   logic [CMP_W-1:0]  r_x, c_x, icol_step, irow_step, ocol_step, orow_step;

   // flow control
   assign mv3       = s2_valid_ff && (!s3_valid_ff || !rsp_stall);
   assign s2_free   = !s2_valid_ff || mv3;
   assign mv2       = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || mv2;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff           <= DIM_W'(1);
         cols_ff           <= DIM_W'(1);
         src_row_stride_ff <= STRIDE_W'(1);
         src_col_stride_ff <= STRIDE_W'(1);
         dst_row_stride_ff <= STRIDE_W'(1);
         dst_col_stride_ff <= STRIDE_W'(1);
         blocked_order_ff  <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROWS:           rows_ff           <= csr_data[DIM_W-1:0];
            CSR_COLS:           cols_ff           <= csr_data[DIM_W-1:0];
            CSR_SRC_ROW_STRIDE: src_row_stride_ff <= csr_data[STRIDE_W-1:0];
            CSR_SRC_COL_STRIDE: src_col_stride_ff <= csr_data[STRIDE_W-1:0];
            CSR_DST_ROW_STRIDE: dst_row_stride_ff <= csr_data[STRIDE_W-1:0];
            CSR_DST_COL_STRIDE: dst_col_stride_ff <= csr_data[STRIDE_W-1:0];
            CSR_BLOCKED_ORDER:  blocked_order_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // clamp sizes to the largest dimension
   always_comb begin
      nr = (32'(rows_ff) > MAX_DIM) ? CMP_W'(MAX_DIM) : CMP_W'(rows_ff);
      nc = (32'(cols_ff) > MAX_DIM) ? CMP_W'(MAX_DIM) : CMP_W'(cols_ff);
   end

   // walk step: restart, position check, element coordinates and advance
   always_comb begin
      if (req_restart) begin
         orow     = '0;
         ocol     = '0;
         irow     = '0;
         icol     = '0;
         rtile    = '0;
         ctile    = '0;
         done_cur = (nr == '0) || (nc == '0);
      end else begin
         orow     = outer_row_ff;
         ocol     = outer_col_ff;
         irow     = inner_row_ff;
         icol     = inner_col_ff;
         rtile    = row_tile_ff;
         ctile    = col_tile_ff;
         done_cur = walk_done_ff;
      end

      orow_x  = CMP_W'(orow);
      ocol_x  = CMP_W'(ocol);
      irow_x  = CMP_W'(irow);
      icol_x  = CMP_W'(icol);
      rtile_x = CMP_W'(rtile);
      ctile_x = CMP_W'(ctile);

      // legal position for the current order and sizes
      if (!blocked_order_ff) begin
         pos_ok = (orow_x < nr) && (ocol_x < nc);
      end else begin
         pos_ok = (orow_x < nr) && (ocol_x < nc)
               && (irow_x >= orow_x) && (irow_x - orow_x < CMP_W'(OUTER_BLOCK))
               && (icol_x >= ocol_x) && (icol_x - ocol_x < CMP_W'(OUTER_BLOCK))
               && (rtile_x < CMP_W'(INNER_BLOCK)) && (ctile_x < CMP_W'(INNER_BLOCK))
               && (irow_x + rtile_x < nr) && (icol_x + ctile_x < nc);
      end

      if (blocked_order_ff) begin
         r_x = irow_x + rtile_x;
         c_x = icol_x + ctile_x;
      end else begin
         r_x = orow_x;
         c_x = ocol_x;
      end

      icol_step = icol_x + CMP_W'(INNER_BLOCK);
      irow_step = irow_x + CMP_W'(INNER_BLOCK);
      ocol_step = ocol_x + CMP_W'(OUTER_BLOCK);
      orow_step = orow_x + CMP_W'(OUTER_BLOCK);

      // next position, default holds
      outer_row_in = orow;
      outer_col_in = ocol;
      inner_row_in = irow;
      inner_col_in = icol;
      row_tile_in  = rtile;
      col_tile_in  = ctile;
      fin          = 1'b0;

      if (!blocked_order_ff) begin
         priority if (ocol_x + CMP_W'(1) < nc) begin
            outer_col_in = IDX_W'(ocol_x + CMP_W'(1));
         end else if (orow_x + CMP_W'(1) < nr) begin
            outer_col_in = '0;
            outer_row_in = IDX_W'(orow_x + CMP_W'(1));
         end else begin
            outer_col_in = '0;
            fin          = 1'b1;
         end
      end else begin
         priority if (ctile_x + CMP_W'(1) < CMP_W'(INNER_BLOCK)
                      && c_x + CMP_W'(1) < nc) begin
            col_tile_in = TILE_W'(ctile_x + CMP_W'(1));
         end else if (rtile_x + CMP_W'(1) < CMP_W'(INNER_BLOCK)
                      && r_x + CMP_W'(1) < nr) begin
            col_tile_in = '0;
            row_tile_in = TILE_W'(rtile_x + CMP_W'(1));
         end else if (icol_step < ocol_step && icol_step < nc) begin
            col_tile_in  = '0;
            row_tile_in  = '0;
            inner_col_in = IDX_W'(icol_step);
         end else if (irow_step < orow_x + CMP_W'(OUTER_BLOCK) && irow_step < nr) begin
            col_tile_in  = '0;
            row_tile_in  = '0;
            inner_col_in = ocol;
            inner_row_in = IDX_W'(irow_step);
         end else if (ocol_step < nc) begin
            col_tile_in  = '0;
            row_tile_in  = '0;
            outer_col_in = IDX_W'(ocol_step);
            inner_col_in = IDX_W'(ocol_step);
            inner_row_in = orow;
         end else if (orow_step < nr) begin
            col_tile_in  = '0;
            row_tile_in  = '0;
            outer_col_in = '0;
            outer_row_in = IDX_W'(orow_step);
            inner_col_in = '0;
            inner_row_in = IDX_W'(orow_step);
         end else begin
            col_tile_in = '0;
            row_tile_in = '0;
            fin         = 1'b1;
         end
      end

      // outcome of this item
      s1_vres_in = 1'b0;
      s1_last_in = 1'b0;
      s1_row_in  = '0;
      s1_col_in  = '0;
      if (done_cur) begin
         walk_done_in = 1'b1;
         outer_row_in = orow;
         outer_col_in = ocol;
         inner_row_in = irow;
         inner_col_in = icol;
         row_tile_in  = rtile;
         col_tile_in  = ctile;
      end else if (!pos_ok) begin
         walk_done_in = 1'b1;
         outer_row_in = orow;
         outer_col_in = ocol;
         inner_row_in = irow;
         inner_col_in = icol;
         row_tile_in  = rtile;
         col_tile_in  = ctile;
      end else begin
         walk_done_in = fin;
         s1_vres_in   = 1'b1;
         s1_last_in   = fin;
         s1_row_in    = IDX_W'(r_x);
         s1_col_in    = IDX_W'(c_x);
      end
   end

   // walk state update
   always_ff @(posedge clock) begin
      if (reset) begin
         outer_row_ff <= '0;
         outer_col_ff <= '0;
         inner_row_ff <= '0;
         inner_col_ff <= '0;
         row_tile_ff  <= '0;
         col_tile_ff  <= '0;
         walk_done_ff <= 1'b1;
      end else if (accept) begin
         outer_row_ff <= outer_row_in;
         outer_col_ff <= outer_col_in;
         inner_row_ff <= inner_row_in;
         inner_col_ff <= inner_col_in;
         row_tile_ff  <= row_tile_in;
         col_tile_ff  <= col_tile_in;
         walk_done_ff <= walk_done_in;
      end
   end

   // pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (!s3_valid_ff || !rsp_stall) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // stage one: element coordinates
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_vres_ff <= s1_vres_in;
         s1_last_ff <= s1_last_in;
         s1_row_ff  <= s1_row_in;
         s1_col_ff  <= s1_col_in;
      end
   end

   // stage two: stride products
   always_ff @(posedge clock) begin
      if (mv2) begin
         s2_vres_ff   <= s1_vres_ff;
         s2_last_ff   <= s1_last_ff;
         p_src_row_ff <= PROD_W'(s1_row_ff * src_row_stride_ff);
         p_src_col_ff <= PROD_W'(s1_col_ff * src_col_stride_ff);
         p_dst_row_ff <= PROD_W'(s1_col_ff * dst_row_stride_ff);
         p_dst_col_ff <= PROD_W'(s1_row_ff * dst_col_stride_ff);
      end
   end

   // stage three: offset sums into the result register
   always_ff @(posedge clock) begin
      if (mv3) begin
         s3_vres_ff <= s2_vres_ff;
         s3_last_ff <= s2_last_ff;
         s3_src_ff  <= OFF_W'(33'(p_src_row_ff) + 33'(p_src_col_ff));
         s3_dst_ff  <= OFF_W'(33'(p_dst_row_ff) + 33'(p_dst_col_ff));
      end
   end

   assign rsp_valid      = s3_valid_ff;
   assign rsp_valid_res  = s3_vres_ff;
   assign rsp_src_offset = s3_src_ff;
   assign rsp_dst_offset = s3_dst_ff;
   assign rsp_last       = s3_last_ff;

endmodule

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stag_pkg::*;

   // the unused slot of the three-bit register index
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam int RANDOM_ITEMS = 750;
   localparam int MAX_SHOWN    = 50;

   typedef struct packed {
      logic             valid_res;
      logic [OFF_W-1:0] src_offset;
      logic [OFF_W-1:0] dst_offset;
      logic             last;
   } move_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_valid_res;
   logic [OFF_W-1:0]     rsp_src_offset;
   logic [OFF_W-1:0]     rsp_dst_offset;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   // restart bits waiting to be sent, element moves waiting to arrive
   bit       restart_queue[$];
   move_type expected_moves[$];
   int       error_count = 0;

   // predicted registers, at their reset values
   logic [DIM_W-1:0]    rows_cfg = 1;
   logic [DIM_W-1:0]    cols_cfg = 1;
   logic [STRIDE_W-1:0] src_row_step = 1;
   logic [STRIDE_W-1:0] src_col_step = 1;
   logic [STRIDE_W-1:0] dst_row_step = 1;
   logic [STRIDE_W-1:0] dst_col_step = 1;
   logic                blocked_cfg = 1'b0;

   // predicted walk position
   int unsigned outer_row = 0, outer_col = 0;
   int unsigned inner_row = 0, inner_col = 0;
   int unsigned tile_row = 0, tile_col = 0;
   bit          walk_idle = 1'b1;

   // handshake pacing
   int unsigned gap_left = 0, stall_left = 0;
   bit          req_burst = 1'b0, rsp_burst = 1'b0;
   move_type    want;

   strided_transpose_address_generator_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_valid_res  (rsp_valid_res),
      .rsp_src_offset (rsp_src_offset),
      .rsp_dst_offset (rsp_dst_offset),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] dim);
      return (dim > MAX_DIM) ? MAX_DIM : dim;
   endfunction

   function automatic int unsigned draw_wait(input bit burst);
      return burst ? 0 : $urandom_range(0, 14);
   endfunction

   // one step of the walk: the element move caused by one item
   function automatic move_type step_walk(input logic restart);
      int unsigned     nr, nc;
      longint unsigned r, c;
      bit              legal, finished;
      move_type        m;
      nr = clamp_dim(rows_cfg);
      nc = clamp_dim(cols_cfg);
      m = '0;
      if (restart) begin
         outer_row = 0; outer_col = 0;
         inner_row = 0; inner_col = 0;
         tile_row = 0; tile_col = 0;
         walk_idle = (nr == 0 || nc == 0);
      end
      if (walk_idle) return m;

      // a reconfigured walk may have left its position behind
      if (!blocked_cfg)
         legal = outer_row < nr && outer_col < nc;
      else
         legal = outer_row < nr && outer_col < nc &&
                 inner_row >= outer_row && inner_row - outer_row < OUTER_BLOCK &&
                 inner_col >= outer_col && inner_col - outer_col < OUTER_BLOCK &&
                 tile_row < INNER_BLOCK && tile_col < INNER_BLOCK &&
                 inner_row + tile_row < nr && inner_col + tile_col < nc;
      if (!legal) begin
         walk_idle = 1'b1;
         return m;
      end

      if (blocked_cfg) begin
         r = inner_row + tile_row;
         c = inner_col + tile_col;
      end else begin
         r = outer_row;
         c = outer_col;
      end
      m.valid_res  = 1'b1;
      m.src_offset = OFF_W'(r * src_row_step + c * src_col_step);
      m.dst_offset = OFF_W'(c * dst_row_step + r * dst_col_step);

      // next position: element, tile, block, each row-major and clipped
      finished = 1'b0;
      if (!blocked_cfg) begin
         if (outer_col + 1 < nc) outer_col++;
         else begin
            outer_col = 0;
            if (outer_row + 1 < nr) outer_row++;
            else finished = 1'b1;
         end
      end else if (tile_col + 1 < INNER_BLOCK && inner_col + tile_col + 1 < nc) begin
         tile_col++;
      end else begin
         tile_col = 0;
         if (tile_row + 1 < INNER_BLOCK && inner_row + tile_row + 1 < nr) tile_row++;
         else begin
            tile_row = 0;
            inner_col += INNER_BLOCK;
            if (!(inner_col < outer_col + OUTER_BLOCK && inner_col < nc)) begin
               inner_col = outer_col;
               inner_row += INNER_BLOCK;
               if (!(inner_row < outer_row + OUTER_BLOCK && inner_row < nr)) begin
                  outer_col += OUTER_BLOCK;
                  if (outer_col < nc) begin
                     inner_row = outer_row;
                     inner_col = outer_col;
                  end else begin
                     outer_col = 0;
                     outer_row += OUTER_BLOCK;
                     if (outer_row < nr) begin
                        inner_row = outer_row;
                        inner_col = 0;
                     end else finished = 1'b1;
                  end
               end
            end
         end
      end
      walk_idle = finished;
      m.last = finished;
      return m;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned exp_val);
      if (error_count < MAX_SHOWN)
         $display("mismatch at %0t: %s got %0h wanted %0h", $realtime, what, got, exp_val);
      error_count++;
   endtask

   // driver: one restart item per handshake, random gap after each
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_restart <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (restart_queue.size() != 0) begin
            req_valid <= 1'b1;
            req_restart <= restart_queue.pop_front();
            if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
            gap_left = draw_wait(req_burst);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: track register writes, predict each item, check each result
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ROWS:           rows_cfg = csr_data[DIM_W-1:0];
               CSR_COLS:           cols_cfg = csr_data[DIM_W-1:0];
               CSR_SRC_ROW_STRIDE: src_row_step = csr_data;
               CSR_SRC_COL_STRIDE: src_col_step = csr_data;
               CSR_DST_ROW_STRIDE: dst_row_step = csr_data;
               CSR_DST_COL_STRIDE: dst_col_step = csr_data;
               CSR_BLOCKED_ORDER:  blocked_cfg = csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) expected_moves.push_back(step_walk(req_restart));

         if (rsp_valid && !rsp_stall) begin
            if (expected_moves.size() == 0) begin
               report_mismatch("unexpected result, src_offset", rsp_src_offset, 0);
            end else begin
               want = expected_moves.pop_front();
               if (rsp_valid_res !== want.valid_res)
                  report_mismatch("valid_res", rsp_valid_res, want.valid_res);
               if (rsp_src_offset !== want.src_offset)
                  report_mismatch("src_offset", rsp_src_offset, want.src_offset);
               if (rsp_dst_offset !== want.dst_offset)
                  report_mismatch("dst_offset", rsp_dst_offset, want.dst_offset);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
            if ($urandom_range(0, 31) == 0) rsp_burst = !rsp_burst;
            stall_left = draw_wait(rsp_burst);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DAT_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for every item to be sent and every move to arrive, then drain
   task automatic settle();
      do @(negedge clock);
      while (restart_queue.size() != 0 || req_valid || expected_moves.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic queue_items(input bit restart, input int unsigned count);
      repeat (count) restart_queue.push_back(restart);
   endtask

   function automatic logic [CSR_DAT_W-1:0] pick_dim();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return CSR_DAT_W'(MAX_DIM);
         2:       return CSR_DAT_W'($urandom_range(MAX_DIM + 1, 8191));
         3:       return CSR_DAT_W'($urandom);
         4, 5, 6: return CSR_DAT_W'($urandom_range(13, 70));
         default: return CSR_DAT_W'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic logic [CSR_DAT_W-1:0] pick_stride();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return CSR_DAT_W'($urandom_range(1, 8));
         default: return CSR_DAT_W'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      int unsigned walk_len, n;
      int          random_items;
      random_items = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // defaults: idle item, then single-element walks
      @(negedge clock);
      queue_items(1'b0, 1);
      queue_items(1'b1, 1);
      queue_items(1'b0, 1);
      queue_items(1'b1, 2);
      settle();

      // zero rows: restart starts nothing
      write_csr(CSR_ROWS, '0);
      @(negedge clock);
      queue_items(1'b1, 1);
      queue_items(1'b0, 1);
      settle();

      // oversize rows clamped, all strides and masked bits at their maximum
      write_csr(CSR_ROWS, '1);
      write_csr(CSR_COLS, 16'd2);
      write_csr(CSR_SRC_ROW_STRIDE, '1);
      write_csr(CSR_SRC_COL_STRIDE, '1);
      write_csr(CSR_DST_ROW_STRIDE, '1);
      write_csr(CSR_DST_COL_STRIDE, '1);
      write_csr(CSR_BLOCKED_ORDER, '1);
      @(negedge clock);
      queue_items(1'b1, 1);
      queue_items(1'b0, 3);
      settle();

      // shrink rows under the running walk: it ends
      write_csr(CSR_ROWS, 16'd1);
      @(negedge clock);
      queue_items(1'b0, 1);
      settle();

      // clipped blocked walk with a zero stride and a write to the spare index
      write_csr(CSR_ROWS, 16'hE005);
      write_csr(CSR_SRC_ROW_STRIDE, '0);
      write_csr(CSR_SRC_COL_STRIDE, 16'd7);
      write_csr(CSR_DST_ROW_STRIDE, 16'd11);
      write_csr(CSR_DST_COL_STRIDE, 16'd3);
      write_csr(CSR_BLOCKED_ORDER, 16'h0001);
      write_csr(CSR_SPARE, '1);
      @(negedge clock);
      queue_items(1'b1, 1);
      queue_items(1'b0, 10);
      settle();

      // random settings, mostly whole walks with the odd restart
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 1)) write_csr(CSR_ROWS, pick_dim());
         if ($urandom_range(0, 1)) write_csr(CSR_COLS, pick_dim());
         if ($urandom_range(0, 1)) write_csr(CSR_SRC_ROW_STRIDE, pick_stride());
         if ($urandom_range(0, 1)) write_csr(CSR_SRC_COL_STRIDE, pick_stride());
         if ($urandom_range(0, 1)) write_csr(CSR_DST_ROW_STRIDE, pick_stride());
         if ($urandom_range(0, 1)) write_csr(CSR_DST_COL_STRIDE, pick_stride());
         if ($urandom_range(0, 1)) write_csr(CSR_BLOCKED_ORDER, CSR_DAT_W'($urandom));
         if ($urandom_range(0, 15) == 0) write_csr(CSR_SPARE, CSR_DAT_W'($urandom));
         @(negedge clock);
         walk_len = clamp_dim(rows_cfg) * clamp_dim(cols_cfg);

         // carry on with the old walk under the new settings
         if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 4);
            queue_items(1'b0, n);
            random_items += n;
         end

         if ($urandom_range(0, 7) == 0) begin
            // noise
            n = $urandom_range(5, 20);
            repeat (n) restart_queue.push_back(1'($urandom_range(0, 1)));
         end else begin
            queue_items(1'b1, 1);
            n = ((walk_len > 72) ? 72 : walk_len) + $urandom_range(0, 3);
            repeat (n) restart_queue.push_back($urandom_range(0, 39) == 0);
            n++;
         end
         random_items += n;
         settle();
      end

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
